FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the encoder value unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed on the encoder value unit");

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed on the encoder value unit");

`endif

FILE: src/edmv_pkg.sv
// ----------------------------------------------------------------------------
// edmv_pkg
// Types and codes shared by the encoder value unit and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package edmv_pkg;

   localparam int SCALED_W   = 20;
   localparam int WIDE_W     = 21;
   localparam int RANGE_W    = 17;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Value modes; the spare code falls back to absolute.
   localparam logic [2:0] VMODE_ABSOLUTE   = 3'd0;
   localparam logic [2:0] VMODE_OFFSET40   = 3'd1;
   localparam logic [2:0] VMODE_TWOS7      = 3'd2;
   localparam logic [2:0] VMODE_SIGNMAG    = 3'd3;
   localparam logic [2:0] VMODE_INC41DEC3F = 3'd4;
   localparam logic [2:0] VMODE_INC01DEC7F = 3'd5;
   localparam logic [2:0] VMODE_INC01DEC41 = 3'd6;
   localparam logic [2:0] VMODE_SPARE_ABS  = 3'd7;

   localparam logic [1:0] SPEED_SLOW   = 2'd0;
   localparam logic [1:0] SPEED_NORMAL = 2'd1;
   localparam logic [1:0] SPEED_FAST   = 2'd2;
   localparam logic [1:0] SPEED_AUTO   = 2'd3;

   localparam logic [6:0] CODE_CENTER = 7'h40;
   localparam logic [6:0] CODE_MAX    = 7'h7f;
   localparam logic [6:0] CODE_41     = 7'h41;
   localparam logic [6:0] CODE_3F     = 7'h3f;
   localparam logic [6:0] CODE_01     = 7'h01;
   localparam logic [5:0] MAG_MAX     = 6'd63;

   localparam logic [2:0] PAR_SLOW   = 3'd3;
   localparam logic [2:0] PAR_NORMAL = 3'd0;
   localparam logic [2:0] PAR_FAST_BASE = 3'd2;
   localparam logic [2:0] PAR_FAST_MAX  = 3'd7;

   localparam logic [RANGE_W-1:0] RANGE_SLOW_LIMIT = RANGE_W'(32);
   localparam logic [RANGE_W-1:0] RANGE_NONDET_MAX = RANGE_W'(256);
   localparam logic [RANGE_W-1:0] RANGE_DET_MAX    = RANGE_W'(64);

   // Register word index, taken from byte address bit 2.
   localparam logic CSR_IDX_SPEED_MULT = 1'b0;

   typedef struct packed {
      logic signed [10:0] delta;
      logic [2:0]         value_mode;
      logic [1:0]         speed_mode;
      logic [2:0]         speed_mode_par;
      logic signed [15:0] range_min;
      logic signed [15:0] range_max;
      logic signed [15:0] current_value;
      logic               detentless;
      logic [1:0]         current_speed;
      logic [2:0]         current_speed_par;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] new_value;
      logic               send;
      logic [1:0]         speed;
      logic [2:0]         speed_param;
      logic               speed_write;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: src/encoder_delta_to_midi_value_unit.sv
// ----------------------------------------------------------------------------
// encoder_delta_to_midi_value_unit
// Turns one encoder movement into the controller value to send and the
// encoder speed setting to use.
// ----------------------------------------------------------------------------
// Each transfer on the request channel carries one encoder delta and the
// settings of its controller; each transfer on the response channel carries
// the matching result, in order. The unit takes one item every clock cycle
// while the response side is not stalled; each item passes through the input
// register and then the result register. The path between them holds the 11
// by 9 bit delta multiply followed by the absolute-mode add and clamp, which
// sets the clock limit. The user writes the fast-mode multiplier through the
// register port at byte address 0 only while the unit is idle; the unit
// itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_delta_to_midi_value_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire edmv_pkg::req_payload_type  req_data,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      edmv_pkg::rsp_payload_type  rsp_data,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [edmv_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [edmv_pkg::CSR_DATA_W-1:0] pwdata,
   output      logic [edmv_pkg::CSR_DATA_W-1:0] prdata,
   output      logic                       pready
);
   import edmv_pkg::*;

   // Pipeline registers.
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic [7:0]      mult_ff, mult_in;

   logic out_free;
   logic s1_free;
   logic csr_write;

   // Datapath signals.
   logic signed [SCALED_W-1:0] product;
   logic signed [SCALED_W-1:0] scaled;
   logic signed [SCALED_W-1:0] neg_scaled;
   logic                       positive;
   logic                       reversed;
   logic signed [15:0]         lo_bound, hi_bound;
   logic signed [WIDE_W-1:0]   abs_sum;
   logic signed [15:0]         abs_value;
   logic signed [WIDE_W-1:0]   off_sum;
   logic [6:0]                 code7;
   logic [5:0]                 mag;
   logic [RANGE_W-1:0]         diff;
   logic [RANGE_W-1:0]         range;
   logic [1:0]                 spd;
   logic [2:0]                 spar;

   // ------------------------------------------------------------------------
   // Handshake. The result register frees when it is empty or being taken;
   // the input register frees when it is empty or moving on. So a waiting
   // result still leaves room for one more item in the input register.
   // ------------------------------------------------------------------------
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign s1_free      = !s1_valid_ff || out_free;
   assign req_stall    = !s1_free;
   assign s1_valid_in  = s1_free ? req_valid : s1_valid_ff;
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Register port. Only the multiplier exists; other word addresses read
   // as zero and ignore writes.
   // ------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[2] == CSR_IDX_SPEED_MULT);
   assign mult_in   = csr_write ? pwdata[7:0] : mult_ff;
   assign prdata    = (paddr[2] == CSR_IDX_SPEED_MULT) ?
                      {{(CSR_DATA_W-8){1'b0}}, mult_ff} : '0;

   // ------------------------------------------------------------------------
   // Delta scaling. The product of an 11 bit signed delta and a multiplier
   // of at most 255 fits 20 bits.
   // ------------------------------------------------------------------------
   assign product    = SCALED_W'(s1_data_ff.delta) *
                       SCALED_W'($signed({1'b0, mult_ff}));
   assign scaled     = (mult_ff > 8'd1) ? product : SCALED_W'(s1_data_ff.delta);
   assign neg_scaled = -scaled;
   assign positive   = scaled > $signed(SCALED_W'(0));

   // A minimum above the maximum means a reversed controller: the delta
   // counts down, and the bounds swap roles.
   assign reversed = s1_data_ff.range_min > s1_data_ff.range_max;
   assign lo_bound = reversed ? s1_data_ff.range_max : s1_data_ff.range_min;
   assign hi_bound = reversed ? s1_data_ff.range_min : s1_data_ff.range_max;
   assign abs_sum  = reversed ?
                     WIDE_W'(s1_data_ff.current_value) - WIDE_W'(scaled) :
                     WIDE_W'(s1_data_ff.current_value) + WIDE_W'(scaled);

   always_comb begin
      if (abs_sum < WIDE_W'(lo_bound)) begin
         abs_value = lo_bound;
      end else if (abs_sum > WIDE_W'(hi_bound)) begin
         abs_value = hi_bound;
      end else begin
         abs_value = abs_sum[15:0];
      end
   end

   assign off_sum = WIDE_W'(scaled) + $signed(WIDE_W'(CODE_CENTER));

   // Magnitude for sign-magnitude mode, saturated at 63.
   always_comb begin
      if (scaled < $signed(SCALED_W'(0))) begin
         mag = (neg_scaled > $signed(SCALED_W'(MAG_MAX))) ? MAG_MAX : neg_scaled[5:0];
      end else begin
         mag = (scaled > $signed(SCALED_W'(MAG_MAX))) ? MAG_MAX : scaled[5:0];
      end
   end

   // Seven bit codes of the relative modes.
   always_comb begin
      case (s1_data_ff.value_mode)
         VMODE_OFFSET40: begin
            if (off_sum < $signed(WIDE_W'(0))) begin
               code7 = '0;
            end else if (off_sum > $signed(WIDE_W'(CODE_MAX))) begin
               code7 = CODE_MAX;
            end else begin
               code7 = off_sum[6:0];
            end
         end
         VMODE_TWOS7:      code7 = scaled[6:0];
         VMODE_SIGNMAG:    code7 = {scaled < $signed(SCALED_W'(0)), mag};
         VMODE_INC41DEC3F: code7 = positive ? CODE_41 : CODE_3F;
         VMODE_INC01DEC7F: code7 = positive ? CODE_01 : CODE_MAX;
         VMODE_INC01DEC41: code7 = positive ? CODE_01 : CODE_41;
         default:          code7 = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Speed choice. The range is 1 to 65536 and needs 17 bits.
   // ------------------------------------------------------------------------
   assign diff  = reversed ?
                  RANGE_W'(s1_data_ff.range_min) - RANGE_W'(s1_data_ff.range_max) :
                  RANGE_W'(s1_data_ff.range_max) - RANGE_W'(s1_data_ff.range_min);
   assign range = diff + RANGE_W'(1);

   always_comb begin
      if (s1_data_ff.speed_mode != SPEED_AUTO) begin
         spd  = s1_data_ff.speed_mode;
         spar = s1_data_ff.speed_mode_par;
      end else if (range < RANGE_SLOW_LIMIT) begin
         spd  = SPEED_SLOW;
         spar = PAR_SLOW;
      end else if (range <= (s1_data_ff.detentless ? RANGE_NONDET_MAX
                                                   : RANGE_DET_MAX)) begin
         spd  = SPEED_NORMAL;
         spar = PAR_NORMAL;
      end else begin
         // Fast: 2 plus one step per 2048 of range, saturated at 7.
         spd  = SPEED_FAST;
         spar = (range[16:11] > 6'd5) ? PAR_FAST_MAX : PAR_FAST_BASE + range[13:11];
      end
   end

   // ------------------------------------------------------------------------
   // Result assembly. Absolute mode (and the spare code) sends only when
   // the clamped value moves.
   // ------------------------------------------------------------------------
   always_comb begin
      if (s1_data_ff.value_mode == VMODE_ABSOLUTE ||
          s1_data_ff.value_mode == VMODE_SPARE_ABS) begin
         rsp_data_in.new_value = abs_value;
         rsp_data_in.send      = abs_value != s1_data_ff.current_value;
      end else begin
         rsp_data_in.new_value = {9'b0, code7};
         rsp_data_in.send      = 1'b1;
      end
      rsp_data_in.speed       = spd;
      rsp_data_in.speed_param = spar;
      rsp_data_in.speed_write = (spd != s1_data_ff.current_speed) ||
                                (spar != s1_data_ff.current_speed_par);
   end

   // ------------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mult_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mult_ff      <= mult_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && req_valid) begin
         s1_data_ff <= req_data;
      end
      if (out_free && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/edmv_checker.sv
// ----------------------------------------------------------------------------
// edmv_checker
// Port-level assertions for the encoder value unit, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module edmv_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire edmv_pkg::rsp_payload_type rsp_data
);
   import edmv_pkg::*;

   // A result held back by the receiver stays put.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

   // The request side is held back only while a result waits to be taken.
   `ASSERT_CLK(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall)

   // An accepted item that can move on out of the input register is registered into the result register and shows up.
   `ASSERT_CLK(a_latency, clock, reset, (req_valid && !req_stall) ##1 (!rsp_valid || !rsp_stall) |=> rsp_valid)

   // Reset empties the result register.
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind encoder_delta_to_midi_value_unit edmv_checker u_edmv_checker (.*);

`default_nettype wire

FILE: sim/encoder_delta_to_midi_value_unit_tb.sv
// ----------------------------------------------------------------------------
// encoder_delta_to_midi_value_unit_tb
// Self-checking bench for the encoder value unit.
// Encoder movements are sent with random gaps, and results are taken under
// random stalls. Each result is checked field by field against an in-bench
// prediction. A short directed set covers the code and range edges, and then
// random phases run under several fast-mode multiplier settings.
// ----------------------------------------------------------------------------

module encoder_delta_to_midi_value_unit_tb;
   import edmv_pkg::*;

   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 6;
   localparam int SETTLE_CYCLES   = 6;
   localparam int MOVES_PER_PHASE = 170;
   localparam int PHASE_COUNT     = 6;
   localparam int FAST_PAR_STEP   = 2048;
   localparam int REPORT_LIMIT    = 10;
   // Worst case is roughly 1100 transfers, each behind the longest send gap and
   // the longest result stall. The limit is more than four times that worst case.
   localparam int RUN_LIMIT       = 8_000_000;

   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_SPEED_MULT = 3'd0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // This is the bench copy of the fast-mode multiplier register.
   logic [7:0] fast_mult = 8'd0;

   // These are the moves waiting to be sent, and the results owed by moves
   // that have already been sent.
   req_payload_type pending_moves[$];
   rsp_payload_type awaited_codes[$];

   // These flags turn idling on or off for each phase. They change only
   // while the unit is idle.
   bit idle_on  = 1'b1;
   bit stall_on = 1'b1;

   int mismatch_count = 0;

   encoder_delta_to_midi_value_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // Predicts the result of one encoder movement under the given multiplier.
   function automatic rsp_payload_type encode_movement(req_payload_type m,
                                                       logic [7:0] mult);
      rsp_payload_type r;
      int scaled, lo, hi, cur, span, v, mag, fast_par;
      logic [1:0] spd;
      logic [2:0] par;
      scaled = $signed(m.delta);
      lo     = $signed(m.range_min);
      hi     = $signed(m.range_max);
      cur    = $signed(m.current_value);
      if (mult > 8'd1)
         scaled = scaled * int'(mult);
      span = (lo <= hi) ? hi - lo + 1 : lo - hi + 1;

      // Speed selection. A given mode passes through. In automatic mode the
      // speed follows the width of the range, and the normal band is wider
      // for non-detented encoders.
      if (m.speed_mode != SPEED_AUTO) begin
         spd = m.speed_mode;
         par = m.speed_mode_par;
      end else if (span < int'(RANGE_SLOW_LIMIT)) begin
         spd = SPEED_SLOW;
         par = PAR_SLOW;
      end else if (span <= (m.detentless ? int'(RANGE_NONDET_MAX)
                                         : int'(RANGE_DET_MAX))) begin
         spd = SPEED_NORMAL;
         par = PAR_NORMAL;
      end else begin
         fast_par = int'(PAR_FAST_BASE) + span / FAST_PAR_STEP;
         spd = SPEED_FAST;
         par = (fast_par > int'(PAR_FAST_MAX)) ? PAR_FAST_MAX : 3'(fast_par);
      end

      r.send = 1'b1;
      case (m.value_mode)
         VMODE_OFFSET40: begin
            v = int'(CODE_CENTER) + scaled;
            if (v < 0)
               v = 0;
            else if (v > int'(CODE_MAX))
               v = int'(CODE_MAX);
         end
         VMODE_TWOS7:
            v = scaled & int'(CODE_MAX);
         VMODE_SIGNMAG: begin
            if (scaled < 0) begin
               mag = (-scaled > int'(MAG_MAX)) ? int'(MAG_MAX) : -scaled;
               v = mag | int'(CODE_CENTER);
            end else begin
               v = (scaled > int'(MAG_MAX)) ? int'(MAG_MAX) : scaled;
            end
         end
         VMODE_INC41DEC3F: v = (scaled > 0) ? int'(CODE_41) : int'(CODE_3F);
         VMODE_INC01DEC7F: v = (scaled > 0) ? int'(CODE_01) : int'(CODE_MAX);
         VMODE_INC01DEC41: v = (scaled > 0) ? int'(CODE_01) : int'(CODE_41);
         default: begin
            // Absolute mode, which the spare code also selects. A reversed
            // range turns the direction of the delta around.
            if (lo <= hi) begin
               v = cur + scaled;
               if (v < lo)
                  v = lo;
               else if (v > hi)
                  v = hi;
            end else begin
               v = cur - scaled;
               if (v < hi)
                  v = hi;
               else if (v > lo)
                  v = lo;
            end
            r.send = (v != cur);
         end
      endcase

      r.new_value   = 16'(v);
      r.speed       = spd;
      r.speed_param = par;
      r.speed_write = (spd != m.current_speed) || (par != m.current_speed_par);
      return r;
   endfunction

   // Gives the length of one idle stretch. Most are short and a few are long.
   function automatic int pick_gap_len();
      return ($urandom_range(0, 99) < 88) ? int'($urandom_range(1, 3))
                                          : int'($urandom_range(10, 40));
   endfunction

   // Builds a random movement. Most moves use realistic controller ranges, with
   // the current value inside the range. The rest use raw field values.
   function automatic req_payload_type rand_move();
      req_payload_type m;
      rsp_payload_type chosen;
      int lo, span, shape;
      shape = $urandom_range(0, 9);
      if (shape < 6)
         m.delta = 11'(int'($urandom_range(0, 8)) - 4);
      else if (shape < 8)
         m.delta = 11'($urandom);
      else
         m.delta = $urandom_range(0, 1) ? 11'sh3ff : 11'sh400;

      case ($urandom_range(0, 5))
         0: span = 127;
         1: span = $urandom_range(0, 300);
         2: span = $urandom_range(0, 65535);
         3: span = 65535;
         default: span = $urandom_range(0, 4000);
      endcase
      lo = (span == 127) ? 0 : int'($urandom_range(0, 65535 - span)) - 32768;
      if ($urandom_range(0, 3) == 0) begin
         m.range_min = 16'(lo + span);
         m.range_max = 16'(lo);
      end else begin
         m.range_min = 16'(lo);
         m.range_max = 16'(lo + span);
      end
      if ($urandom_range(0, 3) != 0)
         m.current_value = 16'(lo + int'($urandom_range(0, span)));
      else
         m.current_value = 16'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         m.range_min = 16'($urandom);
         m.range_max = 16'($urandom);
      end

      m.value_mode        = 3'($urandom);
      m.speed_mode        = 2'($urandom);
      m.speed_mode_par    = 3'($urandom);
      m.detentless        = 1'($urandom);
      m.current_speed     = 2'($urandom);
      m.current_speed_par = 3'($urandom);
      // About a third of the moves already carry the speed that will be
      // chosen. Those moves must not raise speed_write.
      if ($urandom_range(0, 2) == 0) begin
         chosen = encode_movement(m, 8'd0);
         m.current_speed     = chosen.speed;
         m.current_speed_par = chosen.speed_param;
      end
      return m;
   endfunction

   // Queues one directed movement. The speed parameter and the current speed
   // fields stay random.
   task automatic queue_move(input int delta, input logic [2:0] vmode,
                             input logic [1:0] smode, input int lo, input int hi,
                             input int cur, input bit nondet);
      req_payload_type m;
      m = rand_move();
      m.delta         = 11'(delta);
      m.value_mode    = vmode;
      m.speed_mode    = smode;
      m.range_min     = 16'(lo);
      m.range_max     = 16'(hi);
      m.current_value = 16'(cur);
      m.detentless    = nondet;
      pending_moves.push_back(m);
   endtask

   // Writes one register. The setup cycle is followed by the access cycle,
   // and the write takes effect on the edge where pready is seen high.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == CSR_ADDR_SPEED_MULT)
         fast_mult = data[7:0];
   endtask

   // Waits until every queued move has been sent and every result has come
   // back. The pipeline is then given time to settle.
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_moves.size() != 0 || req_valid || awaited_codes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver. When a transfer happens, the driver works out what the
   // unit owes for it. Valid is raised only when a move is pending and no gap
   // is running. Once raised, it stays high with its payload until the
   // transfer takes place.
   always @(posedge clock) begin : driver
      int idle_left;
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_valid && !req_stall)
            awaited_codes.push_back(encode_movement(req_data, fast_mult));
         if (!req_valid || !req_stall) begin
            if (idle_left > 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (pending_moves.size() > 0) begin
               req_data  <= pending_moves.pop_front();
               req_valid <= 1'b1;
               if (idle_on && $urandom_range(0, 99) < 25)
                  idle_left = pick_gap_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and stall generator. Each result transfer is checked
   // against the oldest owed result. Stall stretches of random length are
   // inserted while stalling is enabled.
   always @(posedge clock) begin : monitor
      int stall_left;
      rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_codes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected result: value %0d send %0d speed %0d par %0d write %0d",
                           rsp_data.new_value, rsp_data.send, rsp_data.speed,
                           rsp_data.speed_param, rsp_data.speed_write);
            end else begin
               want = awaited_codes.pop_front();
               if (rsp_data.new_value !== want.new_value || rsp_data.send !== want.send ||
                   rsp_data.speed !== want.speed ||
                   rsp_data.speed_param !== want.speed_param ||
                   rsp_data.speed_write !== want.speed_write) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"mismatch: expected value %0d send %0d speed %0d par %0d ",
                               "write %0d, got value %0d send %0d speed %0d par %0d write %0d"},
                              want.new_value, want.send, want.speed, want.speed_param,
                              want.speed_write, rsp_data.new_value, rsp_data.send,
                              rsp_data.speed, rsp_data.speed_param, rsp_data.speed_write);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (stall_on && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap_len();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Overall time limit for the run.
   initial begin
      #RUN_LIMIT;
      $display("encoder_delta_to_midi_value_unit_tb: errors");
      $finish;
   end

   // Test sequence.
   initial begin : sequencer
      logic [7:0] mult_plan[PHASE_COUNT];
      mult_plan = '{8'd1, 8'd2, 8'd255, 8'd0, 8'd16, 8'd0};
      mult_plan[3] = 8'($urandom_range(3, 254));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed moves run with the multiplier still at its reset value of
      // zero, so every delta passes through unscaled. The first three also
      // cover the given speed modes.
      queue_move(1023,  VMODE_OFFSET40,   SPEED_SLOW,   0, 127, 0, 0);
      queue_move(-1024, VMODE_OFFSET40,   SPEED_NORMAL, 0, 127, 0, 0);
      queue_move(0,     VMODE_OFFSET40,   SPEED_FAST,   0, 127, 0, 1);
      queue_move(-1,    VMODE_TWOS7,      SPEED_AUTO,   0, 127, 0, 0);
      queue_move(-1024, VMODE_TWOS7,      SPEED_AUTO,   0, 127, 0, 0);
      // Sign-magnitude saturates at 63 in both directions.
      queue_move(-1024, VMODE_SIGNMAG,    SPEED_AUTO,   0, 127, 0, 0);
      queue_move(1023,  VMODE_SIGNMAG,    SPEED_AUTO,   0, 127, 0, 0);
      queue_move(-5,    VMODE_SIGNMAG,    SPEED_AUTO,   0, 127, 0, 0);
      // A zero delta selects the decrement code.
      queue_move(0,     VMODE_INC41DEC3F, SPEED_AUTO,   0, 127, 0, 0);
      queue_move(1,     VMODE_INC01DEC7F, SPEED_AUTO,   0, 127, 0, 0);
      queue_move(0,     VMODE_INC01DEC41, SPEED_AUTO,   0, 127, 0, 0);
      queue_move(-1,    VMODE_INC01DEC41, SPEED_AUTO,   0, 127, 0, 0);
      // The spare value mode falls back to absolute.
      queue_move(3,     VMODE_SPARE_ABS,  SPEED_AUTO,   0, 127, 10, 0);
      queue_move(1023,  VMODE_ABSOLUTE,   SPEED_AUTO,   0, 127, 120, 0);
      // Reversed range. Here the second move clamps back to its own current
      // value, so nothing is sent.
      queue_move(5,     VMODE_ABSOLUTE,   SPEED_AUTO,   127, 0, 50, 0);
      queue_move(1,     VMODE_ABSOLUTE,   SPEED_AUTO,   127, 0, 0, 0);
      // A current value outside the range is pulled in even with no movement.
      queue_move(0,     VMODE_ABSOLUTE,   SPEED_AUTO,   0, 127, 500, 0);
      queue_move(0,     VMODE_ABSOLUTE,   SPEED_AUTO,   0, 127, 64, 1);
      // The full 16-bit range pins the value at the top and saturates the
      // fast speed parameter.
      queue_move(1023,  VMODE_ABSOLUTE,   SPEED_AUTO,   -32768, 32767, 32767, 0);
      queue_move(-1024, VMODE_ABSOLUTE,   SPEED_AUTO,   32767, -32768, 32767, 1);
      // These sit on the automatic speed thresholds.
      queue_move(1,     VMODE_ABSOLUTE,   SPEED_AUTO,   0, 30, 0, 0);
      queue_move(1,     VMODE_ABSOLUTE,   SPEED_AUTO,   0, 31, 0, 0);
      queue_move(1,     VMODE_ABSOLUTE,   SPEED_AUTO,   0, 63, 0, 0);
      queue_move(1,     VMODE_ABSOLUTE,   SPEED_AUTO,   0, 64, 0, 0);
      queue_move(1,     VMODE_ABSOLUTE,   SPEED_AUTO,   255, -1, 0, 1);
      wait_idle();

      // Random phases. Each phase uses its own multiplier, and every other
      // phase runs back to back with no idling on either side.
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         csr_write(CSR_ADDR_SPEED_MULT, CSR_DATA_W'(mult_plan[ph]));
         idle_on  = (ph % 2 == 0);
         stall_on = (ph % 2 == 0);
         for (int i = 0; i < MOVES_PER_PHASE; i++)
            pending_moves.push_back(rand_move());
         wait_idle();
      end

      mismatch_count += awaited_codes.size();
      if (mismatch_count == 0)
         $display("encoder_delta_to_midi_value_unit_tb: clean");
      else
         $display("encoder_delta_to_midi_value_unit_tb: errors");
      $finish;
   end

endmodule
